>>> design/assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CBT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("cbt assertion failed");

`define CBT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("cbt forbidden condition seen");

`else

`define CBT_ASSERT(lbl, clk, rstn, prop)

`define CBT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> design/cbt_pkg.sv
`timescale 1ns / 1ps

package cbt_pkg;

    localparam int unsigned COLUMNS = 200;
    localparam int unsigned ROWS    = 120;

    localparam int unsigned LINE_W = 7;
    localparam int unsigned COL_W  = 8;
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned TAB_N  = 1 << COL_W;

    localparam int unsigned LPS  = ROWS / 5;
    localparam int unsigned W_RG = COLUMNS / 7;
    localparam int unsigned W_B  = COLUMNS / 3;
    localparam int unsigned W_GR = COLUMNS / 4;
    localparam int unsigned W_RB = COLUMNS / 5;

    typedef logic [LINE_W-1:0] t_line;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [PIX_W-1:0]  t_pix;
    typedef t_pix [TAB_N-1:0]  t_pix_tab;

    typedef logic [2:0] t_band;
    localparam t_band BAND_RED     = 3'd0;
    localparam t_band BAND_GREEN   = 3'd1;
    localparam t_band BAND_BLUE    = 3'd2;
    localparam t_band BAND_GREY    = 3'd3;
    localparam t_band BAND_RAINBOW = 3'd4;

    localparam int unsigned KIND_RED   = 0;
    localparam int unsigned KIND_GREEN = 1;
    localparam int unsigned KIND_BLUE  = 2;
    localparam int unsigned KIND_GREY  = 3;

    function automatic int unsigned f_sat(int unsigned v, int unsigned top);
        return (v > top) ? top : v;
    endfunction

    function automatic t_pix f_pack(int unsigned r, int unsigned g, int unsigned b);
        return t_pix'(((r & 7) << 5) | ((g & 7) << 2) | (b & 3));
    endfunction

    // Descending ramp, one entry per column; counters stand in for p / w
    function automatic t_pix_tab f_ramp_tab(int unsigned w, int unsigned steps,
                                            int unsigned top, int unsigned kind);
        t_pix_tab    tab;
        int unsigned plen;
        int unsigned endcol;
        int unsigned k;
        int unsigned r;
        int unsigned lvl;
        tab    = '0;
        plen   = steps * w;
        endcol = (plen + 1 > COLUMNS) ? plen + 1 : COLUMNS;
        k      = 0;
        r      = 0;
        for (int unsigned c = 0; c < TAB_N; c++) begin
            if (c == 0 || c >= endcol || plen == 0) begin
                tab[c] = '0;
            end else begin
                lvl = (k > top) ? 0 : top - k;
                case (kind)
                    KIND_RED:   tab[c] = f_pack(lvl, 0, 0);
                    KIND_GREEN: tab[c] = f_pack(0, lvl, 0);
                    KIND_BLUE:  tab[c] = f_pack(0, 0, lvl);
                    default:    tab[c] = t_pix'(lvl * 'h49);
                endcase
                if (c < plen) begin
                    r = r + 1;
                    if (r == w) begin
                        r = 0;
                        k = k + 1;
                    end
                end
            end
        end
        return tab;
    endfunction

    // Rainbow sweep of five sections of cps columns each
    function automatic t_pix_tab f_rainbow_tab(int unsigned cps);
        t_pix_tab    tab;
        int unsigned qc [TAB_N];
        int unsigned qb [TAB_N];
        int unsigned crg;
        int unsigned cb;
        int unsigned plen;
        int unsigned endcol;
        int unsigned s;
        int unsigned o;
        int unsigned inv;
        int unsigned gmax;
        int unsigned bmax;
        int unsigned q1;
        int unsigned r1;
        int unsigned q2;
        int unsigned r2;
        tab = '0;
        crg = cps >> 3;
        cb  = cps >> 2;
        if (crg == 0) crg = 1;
        if (cb == 0) cb = 1;
        q1 = 0;
        r1 = 0;
        q2 = 0;
        r2 = 0;
        for (int unsigned i = 0; i < TAB_N; i++) begin
            qc[i] = q1;
            qb[i] = q2;
            r1 = r1 + 1;
            if (r1 == crg) begin
                r1 = 0;
                q1 = q1 + 1;
            end
            r2 = r2 + 1;
            if (r2 == cb) begin
                r2 = 0;
                q2 = q2 + 1;
            end
        end
        gmax   = f_sat(qc[cps - 1], 7);
        bmax   = f_sat(qb[cps - 1], 3);
        plen   = 5 * cps;
        endcol = (plen + 1 > COLUMNS) ? plen + 1 : COLUMNS;
        s      = 0;
        o      = 0;
        for (int unsigned c = 0; c < TAB_N; c++) begin
            if (c == 0 || c >= endcol || plen == 0) begin
                tab[c] = '0;
            end else begin
                inv = cps - 1 - o;
                case (s)
                    0:       tab[c] = f_pack(7, f_sat(qc[o], 7), 0);
                    1:       tab[c] = f_pack(f_sat(qc[inv], 7), gmax, 0);
                    2:       tab[c] = f_pack(0, gmax, f_sat(qb[o], 3));
                    3:       tab[c] = f_pack(0, f_sat(qc[inv], 7), bmax);
                    default: tab[c] = f_pack(f_sat(qc[o], 7), 0, bmax);
                endcase
                if (c < plen) begin
                    o = o + 1;
                    if (o == cps) begin
                        o = 0;
                        s = s + 1;
                    end
                end
            end
        end
        return tab;
    endfunction

    localparam t_pix_tab TAB_RED     = f_ramp_tab(W_RG, 7, 7, KIND_RED);
    localparam t_pix_tab TAB_GREEN   = f_ramp_tab(W_RG, 7, 7, KIND_GREEN);
    localparam t_pix_tab TAB_BLUE    = f_ramp_tab(W_B, 3, 3, KIND_BLUE);
    localparam t_pix_tab TAB_GREY    = f_ramp_tab(W_GR, 4, 3, KIND_GREY);
    localparam t_pix_tab TAB_RAINBOW = f_rainbow_tab(W_RB);

endpackage

>>> design/cbt_if.sv
`timescale 1ns / 1ps

interface cbt_req_if;
    logic           valid;
    logic           ready;
    cbt_pkg::t_line line;
    cbt_pkg::t_col  column;

    modport source (output valid, output line, output column, input ready);
    modport sink   (input valid, input line, input column, output ready);
endinterface

interface cbt_pix_if;
    logic          valid;
    logic          ready;
    cbt_pkg::t_pix pixel_color;

    modport source (output valid, output pixel_color, input ready);
    modport sink   (input valid, input pixel_color, output ready);
endinterface

>>> design/cbt_lut.sv
`timescale 1ns / 1ps

module cbt_lut (
    input  cbt_pkg::t_line i_line,
    input  cbt_pkg::t_col  i_column,
    output cbt_pkg::t_pix  o_pixel_color
);
    import cbt_pkg::*;

    t_band band;

    always_comb begin
        if (32'(i_line) < LPS) begin
            band = BAND_RED;
        end else if (32'(i_line) < 2 * LPS) begin
            band = BAND_GREEN;
        end else if (32'(i_line) < 3 * LPS) begin
            band = BAND_BLUE;
        end else if (32'(i_line) < 4 * LPS) begin
            band = BAND_GREY;
        end else begin
            band = BAND_RAINBOW;
        end
    end

    always_comb begin
        unique case (band)
            BAND_RED:   o_pixel_color = TAB_RED[i_column];
            BAND_GREEN: o_pixel_color = TAB_GREEN[i_column];
            BAND_BLUE:  o_pixel_color = TAB_BLUE[i_column];
            BAND_GREY:  o_pixel_color = TAB_GREY[i_column];
            default:    o_pixel_color = TAB_RAINBOW[i_column];
        endcase
    end

endmodule

>>> design/color_bar_test_pattern.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Colour bar test pattern: give a line and a column, get one RGB332 pixel.
// One beat is accepted every clock and one pixel leaves every clock while the
// output is not held back. A request that is taken sits in the input register
// until the result register is free, which then loads its colour, and the
// pixel is offered from the result register. The five bands (red, green, blue,
// grey ramps and a rainbow sweep) are constant tables of one entry per column,
// so the only logic per pixel is the band compare and a table read.
// Back-pressure on the output stalls both stages in place.

module color_bar_test_pattern (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cbt_req_if.sink    i_req,
    cbt_pix_if.source  o_pix
);
    import cbt_pkg::*;

    logic  r_s1_valid;
    logic  n_s1_valid;
    t_line r_line;
    t_col  r_column;
    logic  r_s2_valid;
    logic  n_s2_valid;
    t_pix  r_pixel;
    t_pix  lut_pixel;
    logic  s1_ready;
    logic  s2_ready;

    cbt_lut u_lut (
        .i_line        (r_line),
        .i_column      (r_column),
        .o_pixel_color (lut_pixel)
    );

    assign s2_ready    = !r_s2_valid || o_pix.ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_req.ready = s1_ready;

    assign n_s1_valid = s1_ready ? i_req.valid : r_s1_valid;
    assign n_s2_valid = s2_ready ? r_s1_valid : r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_line   <= i_req.line;
            r_column <= i_req.column;
        end
        if (s2_ready) begin
            r_pixel <= lut_pixel;
        end
    end

    assign o_pix.valid       = r_s2_valid;
    assign o_pix.pixel_color = r_pixel;

    `CBT_ASSERT(a_advance, i_clk, i_rst_n, (r_s1_valid && s2_ready) |=> r_s2_valid)
    `CBT_ASSERT(a_hold_result, i_clk, i_rst_n, (r_s2_valid && !o_pix.ready) |=> r_s2_valid)
    `CBT_NEVER(a_no_overrun, i_clk, i_rst_n, r_s1_valid && !s2_ready && i_req.ready)
    `CBT_ASSERT(a_black_lead, i_clk, i_rst_n,
        (r_s1_valid && s2_ready && r_column == '0) |=> (r_pixel == '0))

endmodule

>>> tb/color_bar_test_pattern_test.sv
`timescale 1ns / 1ps

module color_bar_test_pattern_test;
    import cbt_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1825;
    localparam int unsigned QUIET_TAIL   = 150;
    localparam int unsigned HOLD_AFTER   = 400;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned PRINT_CAP    = 40;

    typedef struct packed {
        t_line ln;
        t_col  col;
        logic  known;
        t_pix  want;
    } bar_probe_t;

    localparam int unsigned N_PROBES = 25;

    bar_probe_t bar_probes [N_PROBES] = '{
        '{7'd0,   8'd0,   1'b1, 8'h00},
        '{7'd0,   8'd1,   1'b1, 8'hE0},
        '{7'd0,   8'd196, 1'b0, 8'h00},
        '{7'd0,   8'd199, 1'b0, 8'h00},
        '{7'd0,   8'd200, 1'b1, 8'h00},
        '{7'd23,  8'd255, 1'b1, 8'h00},
        '{7'd24,  8'd1,   1'b1, 8'h1C},
        '{7'd47,  8'd100, 1'b0, 8'h00},
        '{7'd48,  8'd1,   1'b1, 8'h03},
        '{7'd71,  8'd199, 1'b0, 8'h00},
        '{7'd71,  8'd200, 1'b1, 8'h00},
        '{7'd72,  8'd1,   1'b1, 8'hDB},
        '{7'd95,  8'd200, 1'b0, 8'h00},
        '{7'd95,  8'd201, 1'b1, 8'h00},
        '{7'd96,  8'd1,   1'b1, 8'hE0},
        '{7'd96,  8'd40,  1'b0, 8'h00},
        '{7'd96,  8'd41,  1'b0, 8'h00},
        '{7'd100, 8'd81,  1'b0, 8'h00},
        '{7'd110, 8'd121, 1'b0, 8'h00},
        '{7'd119, 8'd161, 1'b0, 8'h00},
        '{7'd119, 8'd200, 1'b0, 8'h00},
        '{7'd120, 8'd100, 1'b0, 8'h00},
        '{7'd127, 8'd201, 1'b1, 8'h00},
        '{7'd127, 8'd127, 1'b0, 8'h00},
        '{7'd85,  8'd170, 1'b0, 8'h00}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    cbt_req_if req_bus ();
    cbt_pix_if pix_bus ();

    color_bar_test_pattern dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_pix   (pix_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_pix        pixel_due [$];
    logic        beat_known;
    t_pix        beat_want;
    int unsigned n_taken  = 0;
    int unsigned n_errors = 0;
    bit          settle   = 1'b0;

    function automatic t_pix rgb332(int unsigned r, int unsigned g, int unsigned b);
        return t_pix'(((r & 7) << 5) | ((g & 7) << 2) | (b & 3));
    endfunction

    function automatic int unsigned clip(int unsigned v, int unsigned top);
        return (v > top) ? top : v;
    endfunction

    function automatic t_pix bar_pixel(t_line ln, t_col col);
        int unsigned row_band;
        t_band       band;
        int unsigned w;
        int unsigned plen;
        int unsigned last_col;
        int unsigned p;
        int unsigned k;
        int unsigned crg;
        int unsigned cb;
        int unsigned sec;
        int unsigned o;
        int unsigned inv;
        int unsigned gmax;
        int unsigned bmax;
        row_band = int'(ln) / (ROWS / 5);
        band     = (row_band > 4) ? BAND_RAINBOW : t_band'(row_band);
        case (band)
            BAND_RED, BAND_GREEN: begin
                w    = COLUMNS / 7;
                plen = 7 * w;
            end
            BAND_BLUE: begin
                w    = COLUMNS / 3;
                plen = 3 * w;
            end
            BAND_GREY: begin
                w    = COLUMNS / 4;
                plen = 4 * w;
            end
            default: begin
                w    = COLUMNS / 5;
                plen = 5 * w;
            end
        endcase
        last_col = (plen + 1 > COLUMNS) ? plen + 1 : COLUMNS;
        if (col == 0 || int'(col) >= last_col || plen == 0) begin
            return '0;
        end
        p = ((int'(col) > plen) ? plen : int'(col)) - 1;
        k = p / w;
        case (band)
            BAND_RED:   return rgb332((k > 7) ? 0 : 7 - k, 0, 0);
            BAND_GREEN: return rgb332(0, (k > 7) ? 0 : 7 - k, 0);
            BAND_BLUE:  return rgb332(0, 0, (k > 3) ? 0 : 3 - k);
            BAND_GREY:  return t_pix'(((k > 3) ? 0 : 3 - k) * 'h49);
            default: begin
                crg  = (w / 8 == 0) ? 1 : w / 8;
                cb   = (w / 4 == 0) ? 1 : w / 4;
                sec  = p / w;
                o    = p % w;
                inv  = w - 1 - o;
                gmax = clip((w - 1) / crg, 7);
                bmax = clip((w - 1) / cb, 3);
                case (sec)
                    0:       return rgb332(7, clip(o / crg, 7), 0);
                    1:       return rgb332(clip(inv / crg, 7), gmax, 0);
                    2:       return rgb332(0, gmax, clip(o / cb, 3));
                    3:       return rgb332(0, clip(inv / crg, 7), bmax);
                    default: return rgb332(clip(o / crg, 7), 0, bmax);
                endcase
            end
        endcase
    endfunction

    task automatic flag_error(string msg);
        if (n_errors < PRINT_CAP) begin
            $display("%0t ERROR %s", $time, msg);
        end
        n_errors++;
    endtask

    task automatic offer_beat(t_line ln, t_col col, logic known, t_pix want);
        if (!settle && $urandom_range(0, 5) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        req_bus.valid  <= 1'b1;
        req_bus.line   <= ln;
        req_bus.column <= col;
        beat_known     <= known;
        beat_want      <= want;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_pix want;
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) begin
                pixel_due.push_back(beat_known ? beat_want
                                               : bar_pixel(req_bus.line, req_bus.column));
                n_taken++;
            end
            if (pix_bus.valid && pix_bus.ready) begin
                if (pixel_due.size() == 0) begin
                    flag_error($sformatf("pixel %02h with nothing outstanding",
                                         pix_bus.pixel_color));
                end else begin
                    want = pixel_due.pop_front();
                    if (pix_bus.pixel_color !== want) begin
                        flag_error($sformatf("pixel_color %02h, want %02h",
                                             pix_bus.pixel_color, want));
                    end
                end
            end
        end
    end

    initial begin
        bit held;
        pix_bus.ready <= 1'b0;
        held = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && n_taken >= HOLD_AFTER) begin
                held = 1'b1;
                pix_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!settle && $urandom_range(0, 3) == 0) begin
                pix_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                pix_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int unsigned n;
        int unsigned start;
        int unsigned run;
        t_line       ln;
        i_rst_n        <= 1'b0;
        req_bus.valid  <= 1'b0;
        req_bus.line   <= '0;
        req_bus.column <= '0;
        beat_known     <= 1'b0;
        beat_want      <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_PROBES; i++) begin
            offer_beat(bar_probes[i].ln, bar_probes[i].col,
                       bar_probes[i].known, bar_probes[i].want);
        end

        n = 0;
        while (n < RANDOM_ITEMS) begin
            ln = t_line'($urandom_range(0, 127));
            if ($urandom_range(0, 9) < 7) begin
                // scanline run: consecutive columns on one line
                start = $urandom_range(0, COLUMNS + 1);
                run   = $urandom_range(1, 40);
                for (int unsigned c = start; c < start + run && c < 256 && n < RANDOM_ITEMS;
                     c++) begin
                    settle = (n >= RANDOM_ITEMS - QUIET_TAIL);
                    offer_beat(ln, t_col'(c), 1'b0, '0);
                    n++;
                end
            end else begin
                settle = (n >= RANDOM_ITEMS - QUIET_TAIL);
                if ($urandom_range(0, 6) == 0) begin
                    offer_beat(ln, t_col'($urandom_range(0, 255)), 1'b0, '0);
                end else begin
                    offer_beat(ln, t_col'($urandom_range(0, COLUMNS + 1)), 1'b0, '0);
                end
                n++;
            end
        end
        req_bus.valid <= 1'b0;

        while (pixel_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
